// File: rtl/gtst_pkg.sv
// ----------------------------------------------------------------------------
// gtst_pkg
// Shared types, codes and helper functions of the text slot table.
// ----------------------------------------------------------------------------
package gtst_pkg;

   // table geometry
   localparam int SLOT_COUNT = 32;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int MAX_OUT    = 32;
   localparam int CNT_W      = $clog2(MAX_OUT);

   // action codes of a request
   localparam logic [2:0] ACT_WRITE  = 3'd0;
   localparam logic [2:0] ACT_ERASE  = 3'd1;
   localparam logic [2:0] ACT_MOVE   = 3'd2;
   localparam logic [2:0] ACT_SETPOS = 3'd3;
   localparam logic [2:0] ACT_SCAN   = 3'd4;

   // decoded operation handed from front to back
   typedef enum logic [2:0] {
      OP_WRITE,
      OP_ERASE,
      OP_MOVE,
      OP_SETPOS,
      OP_SCAN,
      OP_ECHO,   // handle op with slot out of range
      OP_NONE    // unused action code
   } op_type;

   typedef struct packed {
      logic [7:0]         font;
      logic [31:0]        text_address;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [6:0]         scale;
      logic [31:0]        color;
   } entry_type;

   // one word of slot storage
   typedef struct packed {
      logic [31:0] generation;
      entry_type   entry;
   } slot_word_type;

   localparam int WORD_W = $bits(slot_word_type);

   typedef struct packed {
      op_type             op;
      logic [SLOT_W-1:0]  slot;
      logic signed [6:0]  handle_slot;
      logic [31:0]        handle_generation;
      entry_type          entry;
   } cmd_type;

   typedef struct packed {
      logic signed [6:0]  result_slot;
      logic [31:0]        result_generation;
      logic               done_res;
      logic [7:0]         entry_font;
      logic [31:0]        entry_text_address;
      logic signed [15:0] entry_x;
      logic signed [15:0] entry_y;
      logic [6:0]         entry_scale;
      logic [31:0]        entry_color;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] index;
   } ffs_type;

   // lowest set bit
   function automatic ffs_type find_first(input logic [SLOT_COUNT-1:0] vec);
      ffs_type r;
      r.found = 1'b0;
      r.index = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (vec[i]) begin
            r.found = 1'b1;
            r.index = SLOT_W'(i);
         end
      end
      return r;
   endfunction

   // bits strictly above idx
   function automatic logic [SLOT_COUNT-1:0] above_mask(input logic [SLOT_W-1:0] idx);
      logic [SLOT_COUNT-1:0] m;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         m[i] = (i > int'(idx));
      end
      return m;
   endfunction

   // 16-bit signed add, saturating
   function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
      logic signed [16:0] s;
      s = $signed({a[15], a}) + $signed({b[15], b});
      if (!s[16] && s[15]) begin
         return 16'sh7fff;
      end else if (s[16] && !s[15]) begin
         return 16'sh8000;
      end
      return s[15:0];
   endfunction

   // response for none / cleared handle
   function automatic rsp_type rsp_none();
      rsp_type r;
      r.result_slot        = -7'sd1;
      r.result_generation  = '0;
      r.done_res           = 1'b0;
      r.entry_font         = '0;
      r.entry_text_address = '0;
      r.entry_x            = '0;
      r.entry_y            = '0;
      r.entry_scale        = 7'd1;
      r.entry_color        = '0;
      r.last               = 1'b1;
      return r;
   endfunction

endpackage

// File: rtl/gtst_ifs.sv
// ----------------------------------------------------------------------------
// gtst request and response channels
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface gtst_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic signed [6:0]  handle_slot;
   logic [31:0]        handle_generation;
   logic [7:0]         font_number;
   logic [31:0]        text_address;
   logic signed [15:0] x_value;
   logic signed [15:0] y_value;
   logic signed [7:0]  scale_value;
   logic [31:0]        color_value;

   modport source (output valid, action, handle_slot, handle_generation, font_number,
                   text_address, x_value, y_value, scale_value, color_value,
                   input ready);
   modport sink (input valid, action, handle_slot, handle_generation, font_number,
                 text_address, x_value, y_value, scale_value, color_value,
                 output ready);
endinterface

interface gtst_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [6:0]  result_slot;
   logic [31:0]        result_generation;
   logic               done_res;
   logic [7:0]         entry_font;
   logic [31:0]        entry_text_address;
   logic signed [15:0] entry_x;
   logic signed [15:0] entry_y;
   logic [6:0]         entry_scale;
   logic [31:0]        entry_color;
   logic               last;

   modport source (output valid, result_slot, result_generation, done_res, entry_font,
                   entry_text_address, entry_x, entry_y, entry_scale, entry_color, last,
                   input ready);
   modport sink (input valid, result_slot, result_generation, done_res, entry_font,
                 entry_text_address, entry_x, entry_y, entry_scale, entry_color, last,
                 output ready);
endinterface

// File: rtl/generational_text_slot_table_top.sv
// ----------------------------------------------------------------------------
// generational_text_slot_table_top
// Generational handle table of text-label slots: write, erase, move,
// set position and scan over valid/ready request and response channels.
// ----------------------------------------------------------------------------
// A request is decoded and queued (two deep) by the front end, so the request
// side keeps accepting while the queue has room, as the back end works or
// the response waits. The back end takes each command in its idle state, which
// dequeues it and reads the slot RAM, then in its exec state, which updates the
// table and loads the response register once the response slot is free. A scan
// picks listed slots from the active/text flags and streams them through the
// single registered RAM read port, one per cycle while responses are taken.
// Active, generation-valid and text flags are flip-flops cleared by reset,
// so the block is ready as soon as reset is released, with no clearing pass.
// ----------------------------------------------------------------------------
module generational_text_slot_table_top (
   input  logic       clock,
   input  logic       reset,
   gtst_req_if.sink   req_bus,
   gtst_rsp_if.source rsp_bus
);

   logic              q_valid;
   logic              q_pop;
   gtst_pkg::cmd_type q_cmd;

   gtst_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .q_valid(q_valid),
      .q_cmd  (q_cmd),
      .q_pop  (q_pop)
   );

   gtst_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_valid(q_valid),
      .q_cmd  (q_cmd),
      .q_pop  (q_pop),
      .rsp    (rsp_bus)
   );

endmodule

// File: rtl/gtst_ram.sv
// ----------------------------------------------------------------------------
// gtst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gtst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/gtst_front.sv
// ----------------------------------------------------------------------------
// gtst_front
// Accepts requests, decodes them into commands and queues them for the back.
// ----------------------------------------------------------------------------
module gtst_front (
   input  logic              clock,
   input  logic              reset,
   gtst_req_if.sink          req,
   output logic              q_valid,
   output gtst_pkg::cmd_type q_cmd,
   input  logic              q_pop
);

   localparam int QD = 2;
   localparam int PW = $clog2(QD);
   localparam int CW = $clog2(QD + 1);

   gtst_pkg::cmd_type q_ff [QD];
   gtst_pkg::cmd_type dec;
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              push;
   logic              in_range;

   // handle slot must be non-negative and below the slot count
   assign in_range = !req.handle_slot[6] &&
                     ($unsigned(req.handle_slot) < 7'(gtst_pkg::SLOT_COUNT));

   // classify the request
   always_comb begin
      dec.slot              = req.handle_slot[gtst_pkg::SLOT_W-1:0];
      dec.handle_slot       = req.handle_slot;
      dec.handle_generation = req.handle_generation;
      dec.entry.font         = req.font_number;
      dec.entry.text_address = req.text_address;
      dec.entry.x            = req.x_value;
      dec.entry.y            = req.y_value;
      dec.entry.color        = req.color_value;
      // scale below 1 clamps to 1
      if (req.scale_value < 8'sd1) begin
         dec.entry.scale = 7'd1;
      end else begin
         dec.entry.scale = req.scale_value[6:0];
      end
      unique case (req.action)
         gtst_pkg::ACT_WRITE:  dec.op = gtst_pkg::OP_WRITE;
         gtst_pkg::ACT_ERASE:  dec.op = in_range ? gtst_pkg::OP_ERASE  : gtst_pkg::OP_ECHO;
         gtst_pkg::ACT_MOVE:   dec.op = in_range ? gtst_pkg::OP_MOVE   : gtst_pkg::OP_ECHO;
         gtst_pkg::ACT_SETPOS: dec.op = in_range ? gtst_pkg::OP_SETPOS : gtst_pkg::OP_ECHO;
         gtst_pkg::ACT_SCAN:   dec.op = gtst_pkg::OP_SCAN;
         default:              dec.op = gtst_pkg::OP_NONE;
      endcase
   end

   // two-entry command queue
   assign req.ready = (count_ff != CW'(QD));
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = CW'(count_ff + CW'(push) - CW'(q_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// File: rtl/gtst_back.sv
// ----------------------------------------------------------------------------
// gtst_back
// Executes queued commands against the slot storage and drives responses.
// ----------------------------------------------------------------------------
module gtst_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  gtst_pkg::cmd_type q_cmd,
   output logic              q_pop,
   gtst_rsp_if.source        rsp
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } back_state_type;

   localparam int N  = gtst_pkg::SLOT_COUNT;
   localparam int SW = gtst_pkg::SLOT_W;

   back_state_type          state_ff, state_in;
   gtst_pkg::cmd_type       cmd_ff, cmd_in;
   logic [SW-1:0]           addr_ff, addr_in;
   logic                    found_ff, found_in;
   logic [gtst_pkg::CNT_W-1:0] count_ff, count_in;
   logic [N-1:0]            active_ff, active_in;
   logic [N-1:0]            gen_valid_ff, gen_valid_in;
   logic [N-1:0]            text_nz_ff, text_nz_in;
   gtst_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    ram_wr_en, ram_rd_en;
   logic [SW-1:0]           ram_rd_addr;
   logic [gtst_pkg::WORD_W-1:0] ram_wr_data, ram_rd_data;
   gtst_pkg::slot_word_type rd_word, wr_word;
   logic [31:0]             gen_eff, gen_next;
   logic                    match, out_free, scan_last;
   logic [N-1:0]            qual;
   gtst_pkg::ffs_type       pick, next_pick;

   gtst_ram #(
      .WIDTH(gtst_pkg::WORD_W),
      .DEPTH(N)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(addr_ff),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rd_word     = gtst_pkg::slot_word_type'(ram_rd_data);
   assign ram_wr_data = wr_word;
   assign qual        = active_ff & text_nz_ff;
   assign out_free    = !rsp_valid_ff || rsp.ready;

   // never-written generation reads as zero
   assign gen_eff  = gen_valid_ff[addr_ff] ? rd_word.generation : 32'd0;
   assign gen_next = (gen_eff == 32'hffff_ffff) ? 32'd1 : 32'(gen_eff + 32'd1);
   assign match    = active_ff[addr_ff] && (gen_eff == cmd_ff.handle_generation);

   // next listed entry after the current scan slot
   assign next_pick = gtst_pkg::find_first(qual & gtst_pkg::above_mask(addr_ff));
   assign scan_last = !next_pick.found ||
                      (count_ff == gtst_pkg::CNT_W'(gtst_pkg::MAX_OUT - 1));

   // slot picked when a command is dequeued
   always_comb begin
      pick.found = 1'b1;
      pick.index = q_cmd.slot;
      case (q_cmd.op)
         gtst_pkg::OP_WRITE: pick = gtst_pkg::find_first(~active_ff);
         gtst_pkg::OP_SCAN:  pick = gtst_pkg::find_first(qual);
         default:            pick.found = 1'b1;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      active_in    = active_ff;
      gen_valid_in = gen_valid_ff;
      text_nz_in   = text_nz_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      q_pop        = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = pick.index;
      ram_wr_en    = 1'b0;
      wr_word      = rd_word;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               cmd_in    = q_cmd;
               addr_in   = pick.index;
               found_in  = pick.found;
               count_in  = '0;
               ram_rd_en = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = gtst_pkg::rsp_none();
               state_in     = ST_IDLE;
               case (cmd_ff.op)
                  gtst_pkg::OP_WRITE: begin
                     if (found_ff) begin
                        wr_word.generation = gen_next;
                        wr_word.entry      = cmd_ff.entry;
                        ram_wr_en          = 1'b1;
                        active_in[addr_ff]    = 1'b1;
                        gen_valid_in[addr_ff] = 1'b1;
                        text_nz_in[addr_ff]   = (cmd_ff.entry.text_address != 32'd0);
                        rsp_in.result_slot       = $signed(7'(addr_ff));
                        rsp_in.result_generation = gen_next;
                        rsp_in.done_res          = 1'b1;
                     end
                  end
                  gtst_pkg::OP_ERASE: begin
                     if (match) begin
                        active_in[addr_ff] = 1'b0;
                     end
                     rsp_in.done_res = match;
                  end
                  gtst_pkg::OP_MOVE, gtst_pkg::OP_SETPOS: begin
                     if (match) begin
                        if (cmd_ff.op == gtst_pkg::OP_MOVE) begin
                           wr_word.entry.x = gtst_pkg::sat_add(rd_word.entry.x, cmd_ff.entry.x);
                           wr_word.entry.y = gtst_pkg::sat_add(rd_word.entry.y, cmd_ff.entry.y);
                        end else begin
                           wr_word.entry.x = cmd_ff.entry.x;
                           wr_word.entry.y = cmd_ff.entry.y;
                        end
                        ram_wr_en = 1'b1;
                     end
                     rsp_in.result_slot       = cmd_ff.handle_slot;
                     rsp_in.result_generation = cmd_ff.handle_generation;
                     rsp_in.done_res          = match;
                  end
                  gtst_pkg::OP_ECHO: begin
                     rsp_in.result_slot       = cmd_ff.handle_slot;
                     rsp_in.result_generation = cmd_ff.handle_generation;
                  end
                  gtst_pkg::OP_SCAN: begin
                     if (found_ff) begin
                        rsp_in.result_slot        = $signed(7'(addr_ff));
                        rsp_in.result_generation  = gen_eff;
                        rsp_in.done_res           = 1'b1;
                        rsp_in.entry_font         = rd_word.entry.font;
                        rsp_in.entry_text_address = rd_word.entry.text_address;
                        rsp_in.entry_x            = rd_word.entry.x;
                        rsp_in.entry_y            = rd_word.entry.y;
                        rsp_in.entry_scale        = rd_word.entry.scale;
                        rsp_in.entry_color        = rd_word.entry.color;
                        rsp_in.last               = scan_last;
                        // fetch the next listed slot while this one goes out
                        if (!scan_last) begin
                           ram_rd_en   = 1'b1;
                           ram_rd_addr = next_pick.index;
                           addr_in     = next_pick.index;
                           count_in    = gtst_pkg::CNT_W'(count_ff + 1'b1);
                           state_in    = ST_EXEC;
                        end
                     end
                  end
                  default: rsp_in.done_res = 1'b0;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         gen_valid_ff <= '0;
         text_nz_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         gen_valid_ff <= gen_valid_in;
         text_nz_ff   <= text_nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      addr_ff  <= addr_in;
      found_ff <= found_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   // response port
   assign rsp.valid              = rsp_valid_ff;
   assign rsp.result_slot        = rsp_ff.result_slot;
   assign rsp.result_generation  = rsp_ff.result_generation;
   assign rsp.done_res           = rsp_ff.done_res;
   assign rsp.entry_font         = rsp_ff.entry_font;
   assign rsp.entry_text_address = rsp_ff.entry_text_address;
   assign rsp.entry_x            = rsp_ff.entry_x;
   assign rsp.entry_y            = rsp_ff.entry_y;
   assign rsp.entry_scale        = rsp_ff.entry_scale;
   assign rsp.entry_color        = rsp_ff.entry_color;
   assign rsp.last               = rsp_ff.last;

endmodule

// File: tb/gtst_table_checker.sv
// ----------------------------------------------------------------------------
// gtst_table_checker
// Watches the request and response channels of the text slot table, keeps
// its own copy of the slot table, and compares every response, field by
// field, against the oldest expected one.
// ----------------------------------------------------------------------------
module gtst_table_checker
   import gtst_pkg::*;
(
   input  logic clock,
   input  logic reset,
   gtst_req_if  req_mon,
   gtst_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow slot table
   logic        label_live [SLOT_COUNT];
   logic [31:0] label_gen  [SLOT_COUNT];
   entry_type   label_data [SLOT_COUNT];

   rsp_type     expected_rsp_q [$];
   int          mismatches = 0;

   // response carrying only a handle; entry fields at their idle values
   function automatic rsp_type handle_rsp(input logic signed [6:0] slot,
                                          input logic [31:0] gen, input logic done);
      rsp_type r;
      r = '0;
      r.result_slot       = slot;
      r.result_generation = gen;
      r.done_res          = done;
      r.entry_scale       = 7'd1;
      r.last              = 1'b1;
      return r;
   endfunction

   // update the shadow table for one accepted request, queue its responses
   task automatic apply_request();
      int          hs;
      int          free_slot;
      int          total;
      int          listed;
      int          sx;
      int          sy;
      bit          in_range;
      bit          matched;
      logic [31:0] next_gen;
      rsp_type     r;
      hs       = $signed(req_mon.handle_slot);
      in_range = (hs >= 0) && (hs < SLOT_COUNT);
      matched  = 1'b0;
      if (in_range) begin
         matched = label_live[hs] && (label_gen[hs] == req_mon.handle_generation);
      end
      case (req_mon.action)
         ACT_WRITE: begin
            // lowest free slot wins
            free_slot = -1;
            for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
               if (!label_live[i]) free_slot = i;
            end
            if (free_slot < 0) begin
               expected_rsp_q.push_back(handle_rsp(-7'sd1, '0, 1'b0));
            end else begin
               next_gen = label_gen[free_slot] + 32'd1;
               if (next_gen == '0) next_gen = 32'd1;
               label_live[free_slot]              = 1'b1;
               label_gen[free_slot]               = next_gen;
               label_data[free_slot].font         = req_mon.font_number;
               label_data[free_slot].text_address = req_mon.text_address;
               label_data[free_slot].x            = req_mon.x_value;
               label_data[free_slot].y            = req_mon.y_value;
               label_data[free_slot].scale        = ($signed(req_mon.scale_value) < 1) ?
                                                    7'd1 : req_mon.scale_value[6:0];
               label_data[free_slot].color        = req_mon.color_value;
               expected_rsp_q.push_back(handle_rsp(7'(free_slot), next_gen, 1'b1));
            end
         end
         ACT_ERASE, ACT_MOVE, ACT_SETPOS: begin
            if (!in_range) begin
               // handle ignored, echoed back
               expected_rsp_q.push_back(handle_rsp(req_mon.handle_slot,
                                                   req_mon.handle_generation, 1'b0));
            end else if (req_mon.action == ACT_ERASE) begin
               if (matched) begin
                  label_live[hs]              = 1'b0;
                  label_data[hs].text_address = '0;
               end
               expected_rsp_q.push_back(handle_rsp(-7'sd1, '0, matched));
            end else begin
               if (matched && req_mon.action == ACT_MOVE) begin
                  // offsets saturate to the 16-bit range
                  sx = $signed(label_data[hs].x) + $signed(req_mon.x_value);
                  sy = $signed(label_data[hs].y) + $signed(req_mon.y_value);
                  if (sx > 32767) sx = 32767;
                  else if (sx < -32768) sx = -32768;
                  if (sy > 32767) sy = 32767;
                  else if (sy < -32768) sy = -32768;
                  label_data[hs].x = 16'(sx);
                  label_data[hs].y = 16'(sy);
               end else if (matched) begin
                  label_data[hs].x = req_mon.x_value;
                  label_data[hs].y = req_mon.y_value;
               end
               expected_rsp_q.push_back(handle_rsp(req_mon.handle_slot,
                                                   req_mon.handle_generation, matched));
            end
         end
         ACT_SCAN: begin
            // active slots with a text address, in slot order, capped
            total = 0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (label_live[i] && label_data[i].text_address != '0 && total < MAX_OUT)
                  total++;
            end
            if (total == 0) begin
               expected_rsp_q.push_back(handle_rsp(-7'sd1, '0, 1'b0));
            end else begin
               listed = 0;
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (label_live[i] && label_data[i].text_address != '0 &&
                      listed < MAX_OUT) begin
                     r = handle_rsp(7'(i), label_gen[i], 1'b1);
                     r.entry_font         = label_data[i].font;
                     r.entry_text_address = label_data[i].text_address;
                     r.entry_x            = label_data[i].x;
                     r.entry_y            = label_data[i].y;
                     r.entry_scale        = label_data[i].scale;
                     r.entry_color        = label_data[i].color;
                     r.last               = (listed == total - 1);
                     expected_rsp_q.push_back(r);
                     listed++;
                  end
               end
            end
         end
         default: begin
            expected_rsp_q.push_back(handle_rsp(-7'sd1, '0, 1'b0));
         end
      endcase
   endtask

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: response field %s expected %h, got %h", $time, what, want, got);
      end
   endtask

   task automatic check_response();
      rsp_type want;
      if (expected_rsp_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: response with nothing expected, slot %0d generation %h",
                     $time, rsp_mon.result_slot, rsp_mon.result_generation);
      end else begin
         want = expected_rsp_q.pop_front();
         compare_field("result_slot", want.result_slot, rsp_mon.result_slot);
         compare_field("result_generation", want.result_generation,
                       rsp_mon.result_generation);
         compare_field("done_res", want.done_res, rsp_mon.done_res);
         compare_field("entry_font", want.entry_font, rsp_mon.entry_font);
         compare_field("entry_text_address", want.entry_text_address,
                       rsp_mon.entry_text_address);
         compare_field("entry_x", want.entry_x, rsp_mon.entry_x);
         compare_field("entry_y", want.entry_y, rsp_mon.entry_y);
         compare_field("entry_scale", want.entry_scale, rsp_mon.entry_scale);
         compare_field("entry_color", want.entry_color, rsp_mon.entry_color);
         compare_field("last", want.last, rsp_mon.last);
      end
   endtask

   // responses are checked before the same edge's request is applied
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            label_live[i] = 1'b0;
            label_gen[i]  = '0;
         end
         expected_rsp_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_response();
         if (req_mon.valid && req_mon.ready) apply_request();
      end
      pending_results <= expected_rsp_q.size();
      fail_count      <= mismatches;
   end

endmodule

// File: tb/tb_generational_text_slot_table_top.sv
// ----------------------------------------------------------------------------
// tb_generational_text_slot_table_top
// Drives the text slot table with directed and random requests under random
// idling on both channels, including a long response hold-off and drains,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_generational_text_slot_table_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gtst_pkg::*;

   localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;
   localparam int         LONG_HOLD        = 300;

   typedef struct {
      logic [2:0]         action;
      logic signed [6:0]  hslot;
      logic [31:0]        hgen;
      logic [7:0]         font;
      logic [31:0]        text;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [7:0]  scale;
      logic [31:0]        color;
   } label_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_results;

   // stimulus-side knowledge of handles seen on the response channel
   bit          seen_live [SLOT_COUNT];
   logic [31:0] seen_gen  [SLOT_COUNT];

   bit tx_calm       = 1'b0;
   bit rx_calm       = 1'b0;
   bit rsp_hold_req  = 1'b0;
   int tx_gap        = 0;

   gtst_req_if req_bus ();
   gtst_rsp_if rsp_bus ();

   generational_text_slot_table_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   gtst_table_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always #10 clock = ~clock;

   function automatic int draw_gap(input bit calm);
      if (calm || $urandom_range(0, 4) == 0) return 0;
      return $urandom_range(0, 19);
   endfunction

   function automatic logic signed [15:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic label_req_type plain_request(input logic [2:0] act, input int slot,
                                                   input logic [31:0] gen);
      label_req_type r;
      r.action = act;
      r.hslot  = 7'(slot);
      r.hgen   = gen;
      r.font   = '0;
      r.text   = '0;
      r.x      = '0;
      r.y      = '0;
      r.scale  = 8'sd1;
      r.color  = '0;
      return r;
   endfunction

   // mostly live handles, some stale, some out of range, some arbitrary
   function automatic label_req_type aim_handle(input label_req_type r);
      int  pick;
      int  start;
      int  s;
      bit  found;
      pick  = $urandom_range(0, 9);
      start = $urandom_range(0, SLOT_COUNT - 1);
      found = 1'b0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
         s = (start + k) % SLOT_COUNT;
         if (!found && seen_live[s]) begin
            found   = 1'b1;
            r.hslot = 7'(s);
            r.hgen  = seen_gen[s];
         end
      end
      if (pick < 8 && !found) begin
         r.hslot = 7'($urandom_range(0, SLOT_COUNT - 1));
         r.hgen  = $urandom_range(0, 3);
      end else if (pick == 7) begin
         r.hgen = $urandom_range(0, 1) ? r.hgen + 32'd1 : r.hgen - 32'd1;
      end else if (pick == 8) begin
         r.hslot = $urandom_range(0, 1) ? -7'($urandom_range(1, 64))
                                        : 7'($urandom_range(SLOT_COUNT, 63));
      end else if (pick == 9) begin
         r.hslot = 7'($urandom_range(0, 127));
         r.hgen  = $urandom;
      end
      return r;
   endfunction

   function automatic label_req_type random_request(input int w_write, input int w_erase,
                                                    input int w_move, input int w_setpos,
                                                    input int w_scan, input int w_junk);
      label_req_type r;
      int            roll;
      r.hslot = 7'($urandom_range(0, 127));
      r.hgen  = $urandom;
      r.font  = 8'($urandom);
      r.text  = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom);
      r.x     = pick_coord();
      r.y     = pick_coord();
      r.scale = 8'($urandom);
      r.color = $urandom;
      roll = $urandom_range(0, w_write + w_erase + w_move + w_setpos + w_scan + w_junk - 1);
      if (roll < w_write) r.action = ACT_WRITE;
      else if (roll < w_write + w_erase) r.action = ACT_ERASE;
      else if (roll < w_write + w_erase + w_move) r.action = ACT_MOVE;
      else if (roll < w_write + w_erase + w_move + w_setpos) r.action = ACT_SETPOS;
      else if (roll < w_write + w_erase + w_move + w_setpos + w_scan) r.action = ACT_SCAN;
      else r.action = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
      if (r.action == ACT_ERASE || r.action == ACT_MOVE || r.action == ACT_SETPOS)
         r = aim_handle(r);
      return r;
   endfunction

   // valid stays high into the next request when no gap follows
   task automatic send_request(input label_req_type r);
      if (tx_gap > 0) repeat (tx_gap) @(posedge clock);
      req_bus.valid             <= 1'b1;
      req_bus.action            <= r.action;
      req_bus.handle_slot       <= r.hslot;
      req_bus.handle_generation <= r.hgen;
      req_bus.font_number       <= r.font;
      req_bus.text_address      <= r.text;
      req_bus.x_value           <= r.x;
      req_bus.y_value           <= r.y;
      req_bus.scale_value       <= r.scale;
      req_bus.color_value       <= r.color;
      do @(posedge clock); while (!req_bus.ready);
      tx_gap = draw_gap(tx_calm);
      if (tx_gap > 0) req_bus.valid <= 1'b0;
   endtask

   // stop offering and wait until every expected response has arrived
   task automatic drain_requests();
      if (tx_gap == 0) req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic run_phase(input int count, input bit calm_tx, input bit calm_rx,
                            input int w_write, input int w_erase, input int w_move,
                            input int w_setpos, input int w_scan, input int w_junk);
      label_req_type r;
      tx_calm = calm_tx;
      rx_calm = calm_rx;
      for (int n = 0; n < count; n++) begin
         r = random_request(w_write, w_erase, w_move, w_setpos, w_scan, w_junk);
         if (r.action == ACT_ERASE && r.hslot >= 0 && r.hslot < SLOT_COUNT)
            seen_live[r.hslot] = 1'b0;
         send_request(r);
      end
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_hold_req = 1'b0;
         end
         stall = draw_gap(rx_calm);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         // remember handles the table hands out or confirms
         if (rsp_bus.done_res && rsp_bus.result_slot >= 0 &&
             rsp_bus.result_slot < SLOT_COUNT) begin
            seen_live[rsp_bus.result_slot] = 1'b1;
            seen_gen[rsp_bus.result_slot]  = rsp_bus.result_generation;
         end
      end
   end

   // stimulus and verdict
   initial begin
      label_req_type r;
      req_bus.valid             <= 1'b0;
      req_bus.action            <= ACT_SCAN;
      req_bus.handle_slot       <= '0;
      req_bus.handle_generation <= '0;
      req_bus.font_number       <= '0;
      req_bus.text_address      <= '0;
      req_bus.x_value           <= '0;
      req_bus.y_value           <= '0;
      req_bus.scale_value       <= '0;
      req_bus.color_value       <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty table scan, handles out of range, unused action codes
      send_request(plain_request(ACT_SCAN, 0, 0));
      send_request(plain_request(ACT_ERASE, -1, 0));
      send_request(plain_request(ACT_MOVE, SLOT_COUNT, 32'd1));
      send_request(plain_request(ACT_SETPOS, 63, 32'hffff_ffff));
      send_request(plain_request(ACT_ERASE, -64, 32'd1));
      for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++)
         send_request(plain_request(3'(a), 0, 0));
      send_request(plain_request(ACT_ERASE, 0, 0));

      // writes at the field extremes; scale below one is raised to one
      r = plain_request(ACT_WRITE, 0, 0);
      r.font = 8'hff; r.text = '1; r.x = 16'sh7fff; r.y = 16'sh8000;
      r.scale = 8'sh80; r.color = '1;
      send_request(r);
      r = plain_request(ACT_WRITE, 0, 0);
      r.x = 16'sh8000; r.y = 16'sh7fff; r.scale = 8'sh00;
      send_request(r);
      r = plain_request(ACT_WRITE, 0, 0);
      r.text = 32'd1; r.scale = 8'sh7f; r.font = 8'h5a; r.color = 32'h1234_5678;
      send_request(r);
      r = plain_request(ACT_WRITE, 0, 0);
      r.text = 32'h8000_0000; r.scale = 8'sd1;
      send_request(r);

      // move saturating high and low, move back, stale move, set position
      r = plain_request(ACT_MOVE, 0, 32'd1);
      r.x = 16'sh7fff; r.y = 16'sh8000;
      send_request(r);
      r = plain_request(ACT_MOVE, 0, 32'd1);
      r.x = 16'sh8000; r.y = 16'sh7fff;
      send_request(r);
      r = plain_request(ACT_MOVE, 0, 32'd2);
      r.x = 16'sh0100;
      send_request(r);
      r = plain_request(ACT_SETPOS, 2, 32'd1);
      r.x = 16'sh8000; r.y = 16'sh7fff;
      send_request(r);
      send_request(plain_request(ACT_SCAN, 0, 0));

      // erase, erase again, slot reuse with a new generation, stale handle
      send_request(plain_request(ACT_ERASE, 1, 32'd1));
      send_request(plain_request(ACT_ERASE, 1, 32'd1));
      r = plain_request(ACT_WRITE, 0, 0);
      r.text = 32'hcafe_0001; r.scale = 8'sd3;
      send_request(r);
      send_request(plain_request(ACT_SETPOS, 1, 32'd1));
      send_request(plain_request(ACT_SCAN, 0, 0));
      send_request(plain_request(ACT_ERASE, 0, 32'd1));
      send_request(plain_request(ACT_SCAN, 0, 0));
      drain_requests();

      // fill the table past full, then scan it while full
      run_phase(70, 1'b0, 1'b1, 8, 1, 1, 1, 1, 0);
      run_phase(20, 1'b0, 1'b0, 2, 0, 1, 1, 6, 0);
      drain_requests();

      // response side holds off while requests keep coming
      rsp_hold_req = 1'b1;
      run_phase(40, 1'b1, 1'b0, 3, 2, 2, 2, 2, 1);

      // churn and noise
      run_phase(120, 1'b0, 1'b0, 3, 3, 3, 3, 2, 1);
      drain_requests();
      run_phase(50, 1'b1, 1'b1, 3, 3, 3, 3, 2, 1);
      run_phase(50, 1'b0, 1'b0, 4, 2, 2, 2, 3, 1);
      drain_requests();

      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("generational_text_slot_table_top regression: pass");
      end else begin
         $display("generational_text_slot_table_top regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #25ms;
      $display("generational_text_slot_table_top regression: fail");
      $finish;
   end

endmodule

// File: generational_text_slot_table_top.f
rtl/gtst_pkg.sv
rtl/gtst_ifs.sv
rtl/gtst_ram.sv
rtl/gtst_front.sv
rtl/gtst_back.sv
rtl/generational_text_slot_table_top.sv
tb/gtst_table_checker.sv
tb/tb_generational_text_slot_table_top.sv
